@@ src/rss_pkg.sv @@
// ----------------------------------------------------------------------------
// rss_pkg
// Shared types, sizes and helpers for the RGB 3x3 sharpen stream.
// ----------------------------------------------------------------------------
package rss_pkg;

    localparam int LINE_WIDTH = 1280;
    localparam int LANES      = 3;
    localparam int COL_W      = $clog2(LINE_WIDTH);

    localparam logic [COL_W-1:0] LAST_COL = COL_W'(LINE_WIDTH - 1);

    typedef logic [23:0]      pix_t;
    typedef logic [COL_W-1:0] col_t;
    typedef logic [1:0]       lane_t;

    // One memory row holds the same column of all three lines.
    typedef logic [LANES-1:0][23:0] row_t;

    typedef struct packed {
        pix_t pixel_in;
        logic frame_start;
        logic line_end;
    } in_item_t;

    typedef struct packed {
        pix_t pixel_out;
        logic frame_start_out;
        logic line_end_out;
    } out_item_t;

    // Access to the line memory: read the row, replace one lane.
    typedef struct packed {
        logic  access;
        col_t  col;
        lane_t lane;
        pix_t  pix;
    } mem_req_t;

    localparam lane_t LANE_LAST = lane_t'(LANES - 1);

    function automatic lane_t lane_inc(input lane_t l);
        lane_t r;
        r = (l >= LANE_LAST) ? '0 : lane_t'(l + lane_t'(1));
        return r;
    endfunction

endpackage

@@ src/rss_line_mem.sv @@
// ----------------------------------------------------------------------------
// rss_line_mem
// Line memory: one row per column, three line lanes per row. Cleared by a
// sweep after reset; read of the full row and write of one lane per access.
// ----------------------------------------------------------------------------
module rss_line_mem
    import rss_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  mem_req_t req,
    output row_t     rd_row,
    output logic     clearing
);

    row_t mem [LINE_WIDTH];

    logic clearing_reg;
    col_t clr_col_reg;
    row_t rd_row_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg <= 1'b1;
            clr_col_reg  <= '0;
        end else if (clearing_reg) begin
            if (clr_col_reg == LAST_COL) begin
                clearing_reg <= 1'b0;
            end else begin
                clr_col_reg <= clr_col_reg + col_t'(1);
            end
        end
    end

    // Read returns the old row; the top level never uses the written lane from it.
    always_ff @(posedge aclk) begin
        if (clearing_reg) begin
            mem[clr_col_reg] <= '0;
        end else if (req.access) begin
            mem[req.col][req.lane] <= req.pix;
        end
        if (req.access) begin
            rd_row_reg <= mem[req.col];
        end
    end

    assign rd_row   = rd_row_reg;
    assign clearing = clearing_reg;

endmodule

@@ src/rss_filter.sv @@
// ----------------------------------------------------------------------------
// rss_filter
// Sliding 3x3 window and sharpen kernel (center 5, edge neighbors -1).
// ----------------------------------------------------------------------------
module rss_filter
    import rss_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic shift,
    input  pix_t top_pix,
    input  pix_t mid_pix,
    input  pix_t bot_pix,
    output pix_t result
);

    // Only the taps the kernel uses are kept; corners never contribute.
    pix_t top_r_reg;
    pix_t bot_r_reg;
    pix_t mid_c_reg;
    pix_t mid_r_reg;

    function automatic logic [7:0] sharpen_ch(
        input logic [7:0] c,
        input logic [7:0] l,
        input logic [7:0] r,
        input logic [7:0] t,
        input logic [7:0] b
    );
        logic signed [11:0] sum;
        logic        [10:0] mag;
        logic        [7:0]  res;
        sum = $signed({2'b00, c, 2'b00}) + $signed({4'b0000, c})
            - $signed({4'b0000, l}) - $signed({4'b0000, r})
            - $signed({4'b0000, t}) - $signed({4'b0000, b});
        mag = sum[11] ? 11'(-sum) : sum[10:0];
        res = (mag > 11'd255) ? 8'hFF : mag[7:0];
        return res;
    endfunction

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            result[ch*8 +: 8] = sharpen_ch(mid_r_reg[ch*8 +: 8], mid_c_reg[ch*8 +: 8],
                                           mid_pix[ch*8 +: 8], top_r_reg[ch*8 +: 8],
                                           bot_r_reg[ch*8 +: 8]);
        end
    end

    // Advance the window one column per item.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            top_r_reg <= '0;
            bot_r_reg <= '0;
            mid_c_reg <= '0;
            mid_r_reg <= '0;
        end else if (shift) begin
            top_r_reg <= top_pix;
            bot_r_reg <= bot_pix;
            mid_c_reg <= mid_r_reg;
            mid_r_reg <= mid_pix;
        end
    end

endmodule

@@ src/rgb_sharpen_3x3_stream.sv @@
// ----------------------------------------------------------------------------
// rgb_sharpen_3x3_stream
// 3x3 sharpen filter over a stream of 24-bit RGB pixels.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_data carry one input item per handshake: a pixel (red
//   7:0, green 15:8, blue 23:16) with start-of-frame and end-of-line flags.
//   m_valid/m_ready/m_data return exactly one filtered item per input, in
//   order, flags copied through unchanged.
// Path: an accepted item passes the read stage, then the output register, to m_data.
// Throughput: one item per cycle while m_ready is high. The single line-memory
//   port reads the row of the current column and writes the new pixel into it at
//   the accept edge, so every item needs exactly one memory access.
// Reset: aresetn (synchronous, active low) clears the window, column and line
//   rotation, then a clearing pass writes zero to all LINE_WIDTH memory rows,
//   one row per cycle; s_ready stays low until the pass is done.
// Stall: when m_ready is low the output register holds, the read stage holds
//   one more item, and s_ready drops only once both are full.
// There is no border handling: the window runs across line and frame ends.
// ----------------------------------------------------------------------------
module rgb_sharpen_3x3_stream
    import rss_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    // Column and line rotation of the next item
    col_t  col_reg;
    lane_t rot_reg;

    // Read stage: item waiting for its memory row
    logic     b_valid_reg;
    in_item_t b_item_reg;
    lane_t    b_rot_reg;

    // Output register
    logic      m_valid_reg;
    out_item_t m_data_reg;

    logic     clearing;
    logic     accept;
    logic     b_adv;
    col_t     col_use;
    col_t     col_next;
    lane_t    rot_next;
    mem_req_t req;
    row_t     rd_row;
    pix_t     top_pix;
    pix_t     mid_pix;
    pix_t     filt_pix;

    assign b_adv   = b_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !clearing && (!b_valid_reg || b_adv);
    assign accept  = s_valid && s_ready;

    // Start-of-frame zeroes the column before this pixel is used.
    assign col_use = s_data.frame_start ? '0 : col_reg;

    always_comb begin
        col_next = col_reg;
        rot_next = rot_reg;
        if (accept) begin
            if (s_data.line_end) begin
                col_next = '0;
                rot_next = lane_inc(rot_reg);
            end else if (col_use == LAST_COL) begin
                col_next = '0;     // overlong line: wrap
            end else begin
                col_next = col_use + col_t'(1);
            end
        end
    end

    // Read lanes L and L+1, write the new pixel into lane L+2 of this column.
    always_comb begin
        req.access = accept;
        req.col    = col_use;
        req.lane   = lane_inc(lane_inc(rot_reg));
        req.pix    = s_data.pixel_in;
    end

    rss_line_mem u_mem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (req),
        .rd_row   (rd_row),
        .clearing (clearing)
    );

    assign top_pix = rd_row[b_rot_reg];
    assign mid_pix = rd_row[lane_inc(b_rot_reg)];

    rss_filter u_filter (
        .aclk    (aclk),
        .aresetn (aresetn),
        .shift   (b_adv),
        .top_pix (top_pix),
        .mid_pix (mid_pix),
        .bot_pix (b_item_reg.pixel_in),
        .result  (filt_pix)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg     <= '0;
            rot_reg     <= '0;
            b_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            col_reg <= col_next;
            rot_reg <= rot_next;
            // advance the read stage
            if (accept) begin
                b_valid_reg <= 1'b1;
            end else if (b_adv) begin
                b_valid_reg <= 1'b0;
            end
            // load or drop the output item
            if (b_adv) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: hold unless their stage advances.
    always_ff @(posedge aclk) begin
        if (accept) begin
            b_item_reg <= s_data;
            b_rot_reg  <= rot_reg;
        end
        if (b_adv) begin
            m_data_reg.pixel_out       <= filt_pix;
            m_data_reg.frame_start_out <= b_item_reg.frame_start;
            m_data_reg.line_end_out    <= b_item_reg.line_end;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

@@ src/rss_checker.sv @@
// ----------------------------------------------------------------------------
// rss_checker
// Port-level checks for rgb_sharpen_3x3_stream, attached by bind.
// ----------------------------------------------------------------------------
module rss_checker
    import rss_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);

    logic [1:0] inflight_reg;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = s_valid && s_ready;
    assign out_acc = m_valid && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inflight_reg <= '0;
        end else begin
            inflight_reg <= inflight_reg + 2'(in_acc) - 2'(out_acc);
        end
    end

    // Clearing pass blocks input right after reset.
    a_ready_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("s_ready high right after reset");

    // No stale item survives reset.
    a_valid_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("m_valid high right after reset");

    // Every result belongs to an accepted item.
    a_no_invented: assert property (@(posedge aclk) disable iff (!aresetn)
        out_acc |-> (inflight_reg != 2'd0))
        else $error("result without a pending item");

    // At most two items are held inside.
    a_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        inflight_reg != 2'd3)
        else $error("more than two items in flight");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

endmodule

bind rgb_sharpen_3x3_stream rss_checker u_rss_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the RGB 3x3 sharpen stream: a queued pixel driver,
// a line-store and window predictor kept in step with every accepted item,
// and a monitor that compares each filtered item against the prediction.
// ----------------------------------------------------------------------------
module tb_top;
    import rss_pkg::*;

    // One queued input item with its pacing: idle cycles before it, and
    // whether the driver must first wait for every result to come back.
    typedef struct {
        in_item_t    item;
        int unsigned gap;
        bit          drain;
    } stim_t;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    stim_t       stim_q[$];
    out_item_t   expected_px[$];
    int unsigned n_checked  = 0;
    int unsigned n_bad      = 0;
    int unsigned quiet_from = '1;

    // Predictor state: three line stores, the 3x3 window, column and rotations
    pix_t        line_mem [3][LINE_WIDTH];
    pix_t        win_px [3][3];
    int unsigned col  = 0;
    int unsigned lrot = 0;
    int unsigned wrot = 0;

    // Driver and monitor pacing
    int unsigned gap_cnt   = 0;
    int unsigned stall_cnt = 0;
    int unsigned sink_span = 0;
    bit          sink_busy = 1'b0;
    out_item_t   want;

    rgb_sharpen_3x3_stream u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        aclk = 1'b1;
        #4;
        aclk = 1'b0;
        #4;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // A colour lane of the sharpen kernel: the centre times 5 minus the north,
    // west, east and south neighbours, then magnitude, clipped at 255.
    function automatic logic [7:0] sharpen_lane(input pix_t north, input pix_t west,
                                                input pix_t mid, input pix_t east,
                                                input pix_t south, input int sh);
        int acc;
        acc = 5 * int'(mid[sh +: 8]) - int'(west[sh +: 8]) - int'(east[sh +: 8])
            - int'(north[sh +: 8]) - int'(south[sh +: 8]);
        if (acc < 0)
            acc = -acc;
        return (acc > 255) ? 8'hFF : acc[7:0];
    endfunction

    // Advance the predictor by one accepted item and return the filtered item.
    function automatic out_item_t sharpen_step(input in_item_t it);
        out_item_t   res;
        int unsigned slot;
        int unsigned cen;
        // start-of-frame only clears the column; rotations carry on
        if (it.frame_start)
            col = 0;
        slot = (wrot + 2) % 3;
        cen  = (wrot + 1) % 3;
        // load the newest window column: two stored lines above, live pixel below
        win_px[0][slot] = line_mem[lrot][col];
        win_px[1][slot] = line_mem[(lrot + 1) % 3][col];
        win_px[2][slot] = it.pixel_in;
        for (int sh = 0; sh < 24; sh += 8) begin
            res.pixel_out[sh +: 8] = sharpen_lane(win_px[0][cen], win_px[1][wrot],
                                                  win_px[1][cen], win_px[1][slot],
                                                  win_px[2][cen], sh);
        end
        res.frame_start_out = it.frame_start;
        res.line_end_out    = it.line_end;
        // store the pixel at its own column before the column moves on
        line_mem[(lrot + 2) % 3][col] = it.pixel_in;
        if (it.line_end) begin
            col  = 0;
            lrot = (lrot + 1) % 3;
        end else begin
            col++;
            // overlong line: wrap without a line end
            if (col >= LINE_WIDTH)
                col = 0;
        end
        wrot = (wrot + 1) % 3;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Driver: one item per handshake, random gaps taken from the queue
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            gap_cnt = 0;
        end else begin
            // predict on acceptance so the expected order is the accepted order
            if (s_valid && s_ready)
                expected_px.push_back(sharpen_step(s_data));
            // the output slot is free when nothing is held or it just left
            if (!s_valid || s_ready) begin
                if (stim_q.size() == 0) begin
                    s_valid <= 1'b0;
                end else if (stim_q[0].drain && expected_px.size() != 0) begin
                    // hold off until the block has returned everything
                    s_valid <= 1'b0;
                end else if (gap_cnt < stim_q[0].gap) begin
                    gap_cnt++;
                    s_valid <= 1'b0;
                end else begin
                    s_data  <= stim_q[0].item;
                    s_valid <= 1'b1;
                    stim_q.pop_front();
                    gap_cnt = 0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: compare each returned item, drive back-pressure in bursts
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_cnt = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_px.size() == 0) begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display("item %0d: nothing expected, got pix=%h fs=%b le=%b",
                                 n_checked, m_data.pixel_out, m_data.frame_start_out,
                                 m_data.line_end_out);
                end else begin
                    want = expected_px.pop_front();
                    if (m_data.pixel_out !== want.pixel_out
                        || m_data.frame_start_out !== want.frame_start_out
                        || m_data.line_end_out !== want.line_end_out) begin
                        n_bad++;
                        if (n_bad <= 10)
                            $display("item %0d: exp pix=%h fs=%b le=%b, got pix=%h fs=%b le=%b",
                                     n_checked, want.pixel_out, want.frame_start_out,
                                     want.line_end_out, m_data.pixel_out,
                                     m_data.frame_start_out, m_data.line_end_out);
                    end
                end
                n_checked++;
            end
            // alternate busy and calm stretches on the sink side
            if (sink_span == 0) begin
                sink_span = $urandom_range(20, 150);
                sink_busy = ($urandom_range(0, 2) != 0);
            end else begin
                sink_span--;
            end
            if (stall_cnt != 0) begin
                stall_cnt--;
                m_ready <= 1'b0;
            end else if (sink_busy && n_checked < quiet_from && $urandom_range(0, 4) == 0) begin
                // start a stall burst; m_ready stays low while stall_cnt counts down
                stall_cnt = $urandom_range(0, 4);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    function automatic int unsigned pick_gap(input bit calm);
        if (calm || $urandom_range(0, 3) != 0)
            return 0;
        return $urandom_range(1, 5);
    endfunction

    // Mix of full-random, saturated-extreme and smooth pixels; smooth ones add
    // 0..6 to a base per lane, so the unclipped path of the kernel gets exercised.
    function automatic pix_t pick_pixel(input pix_t base);
        pix_t p;
        int unsigned mode;
        mode = $urandom_range(0, 3);
        p    = pix_t'($urandom);
        for (int sh = 0; sh < 24; sh += 8) begin
            if (mode == 1)
                p[sh +: 8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            else if (mode >= 2)
                p[sh +: 8] = 8'(base[sh +: 8] + $urandom_range(0, 6));
        end
        return p;
    endfunction

    task automatic add_px(input pix_t p, input bit fs, input bit le,
                          input int unsigned gap, input bit drain);
        stim_t s;
        s.item.pixel_in    = p;
        s.item.frame_start = fs;
        s.item.line_end    = le;
        s.gap              = gap;
        s.drain            = drain;
        stim_q.push_back(s);
    endtask

    // A frame of h lines of w pixels, random content; start-of-frame only if with_fs.
    task automatic add_frame(input int unsigned w, input int unsigned h, input bit calm,
                             input bit with_fs, input bit drain_first);
        pix_t base;
        base = pix_t'($urandom);
        for (int unsigned y = 0; y < h; y++) begin
            for (int unsigned x = 0; x < w; x++) begin
                add_px(pick_pixel(base), with_fs && y == 0 && x == 0, x == w - 1,
                       pick_gap(calm), drain_first && y == 0 && x == 0);
            end
        end
    endtask

    initial begin : gen
        int unsigned start;
        int unsigned pick;
        bit          calm;

        foreach (line_mem[i, j])
            line_mem[i][j] = '0;
        foreach (win_px[i, j])
            win_px[i][j] = '0;

        // Directed: extremes in every lane, a checkerboard that saturates
        add_px(24'h000000, 1'b1, 1'b0, 0, 1'b0);
        add_px(24'hFFFFFF, 1'b0, 1'b0, 0, 1'b0);
        add_px(24'h000000, 1'b0, 1'b0, 0, 1'b0);
        add_px(24'hFFFFFF, 1'b0, 1'b1, 0, 1'b0);
        add_px(24'hFFFFFF, 1'b0, 1'b0, 0, 1'b0);
        add_px(24'h000000, 1'b0, 1'b0, 0, 1'b0);
        add_px(24'h0000FF, 1'b0, 1'b0, 0, 1'b0);
        add_px(24'h00FF00, 1'b0, 1'b1, 0, 1'b0);
        add_px(24'hFF0000, 1'b0, 1'b0, 0, 1'b0);
        add_px(24'h808080, 1'b0, 1'b0, 0, 1'b0);
        add_px(24'h7F7F7F, 1'b0, 1'b0, 0, 1'b0);
        add_px(24'h010101, 1'b0, 1'b1, 0, 1'b0);
        // both flags on one pixel: single-pixel line that also starts a frame
        add_px(24'h123456, 1'b1, 1'b1, 0, 1'b0);
        add_px(24'h555555, 1'b0, 1'b0, 0, 1'b0);
        add_px(24'hAAAAAA, 1'b0, 1'b0, 0, 1'b0);
        // start-of-frame in the middle of a line clears only the column
        add_px(24'h404040, 1'b1, 1'b0, 0, 1'b0);
        add_px(24'h3C3C3C, 1'b0, 1'b0, 0, 1'b0);
        add_px(24'h444444, 1'b0, 1'b1, 0, 1'b0);
        add_px(24'hFFFFFF, 1'b0, 1'b0, 0, 1'b0);
        add_px(24'h000000, 1'b0, 1'b1, 0, 1'b0);

        // Overlong line: run past LINE_WIDTH so the column wraps by itself.
        // Drain first so the pause happens at least once.
        start = $urandom;
        for (int unsigned x = 0; x < LINE_WIDTH + 1; x++)
            add_px(pick_pixel(pix_t'(start)), 1'b0, x == LINE_WIDTH,
                   pick_gap(1'b0), x == 0);

        // Random part: mostly well-formed frames, some noise and headless lines
        start = stim_q.size();
        while (stim_q.size() - start < 24) begin
            calm = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 9);
            if (pick <= 6) begin
                add_frame($urandom_range(3, 12), $urandom_range(1, 4), calm, 1'b1,
                          $urandom_range(0, 7) == 0);
            end else if (pick <= 8) begin
                repeat ($urandom_range(1, 30))
                    add_px(pix_t'($urandom), $urandom_range(0, 15) == 0,
                           $urandom_range(0, 7) == 0, pick_gap(calm), 1'b0);
            end else begin
                add_frame($urandom_range(1, 12), $urandom_range(1, 4), calm, 1'b0, 1'b0);
            end
        end

        // Tail: no idling on either side
        quiet_from = stim_q.size();
        add_frame(8, 4, 1'b1, 1'b1, 1'b0);

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // wait for the queue to empty and the last item to be taken
        while (stim_q.size() != 0 || s_valid)
            @(posedge aclk);
        while (expected_px.size() != 0)
            @(posedge aclk);
        // let any stray item out before judging
        repeat (16) @(posedge aclk);

        if (n_bad == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

    // Watchdog: well past the slowest legal run including the clearing pass
    initial begin
        #3_000_000;
        $display("tb_top: done, errors");
        $finish;
    end

endmodule

@@ sim.f @@
src/rss_pkg.sv
src/rss_line_mem.sv
src/rss_filter.sv
src/rgb_sharpen_3x3_stream.sv
src/rss_checker.sv
tb/tb_top.sv
